/* src/assert_macros.svh */
// Assertion macros shared by the sprite decoder RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define RSD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed in %m");
// Condition must never be true at a clock edge outside reset.
`define RSD_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen in %m");
`else
`define RSD_ASSERT(label, clk, rst_n, prop)
`define RSD_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* src/rsd_pkg.sv */
// Shared types and constants of the RLE sprite decoder.
// No dependencies; used by every module of the block.
package rsd_pkg;

	localparam int DATA_W   = 8;
	localparam int ADDR_W   = 20;
	localparam int SPAN_W   = 9;
	localparam int COLOR_W  = 16;
	localparam int BIDX_W   = 18;
	localparam int PIX_W    = 17;
	localparam int ROW_W    = 8;
	localparam int RUN_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 18;
	localparam int Q_DEPTH  = 4;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PLACE    = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic {
		KIND_SPAN   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd4;

	typedef struct packed {
		logic [9:0]        origin_x;
		logic [9:0]        origin_y;
		logic [10:0]       surface_width;
		logic [10:0]       surface_height;
		logic [BIDX_W-1:0] frame_length;
	} cfg_t;

	// One queue entry: the work one coded byte leaves for the back end.
	typedef struct packed {
		logic               has_span;
		logic [RUN_W-1:0]   span_len;
		logic [COLOR_W-1:0] color;
		logic               has_status;
		status_t            status;
	} entry_t;

endpackage

/* src/rsd_front.sv */
// Front end of the RLE sprite decoder: takes coded bytes, tracks the run
// state and errors, and hands span and status work to the queue. Uses rsd_pkg.
module rsd_front #(
	parameter int SPRITE_WIDTH  = 64,
	parameter int SPRITE_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsd_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rsd_pkg::DATA_W-1:0] data_byte,
	input  logic                       q_full,
	output logic                       q_push,
	output rsd_pkg::entry_t            q_entry
);
	import rsd_pkg::*;

	localparam logic [PIX_W:0] TOTAL = (PIX_W+1)'(SPRITE_WIDTH * SPRITE_HEIGHT);

	typedef enum logic [1:0] {PH_CTRL, PH_HI, PH_LO} phase_t;

	phase_t              phase_q, phase_n;
	logic [BIDX_W-1:0]   byte_idx_q;
	logic [PIX_W-1:0]    pix_q, pix_n;
	logic                fill_q, fill_n;
	logic [6:0]          rem_q, rem_n;
	logic [7:0]          hi_q, hi_n;
	status_t             err_q, err_n, st;

	logic [BIDX_W-1:0]   fl;
	logic [BIDX_W:0]     cnt;
	logic                at_end, place_bad, trunc, span, accept;
	logic [RUN_W-1:0]    run_len, span_len;
	logic [8:0]          need;

	always_comb begin
		fl = (cfg.frame_length == '0) ? BIDX_W'(1) : cfg.frame_length;
		cnt = {1'b0, byte_idx_q} + (BIDX_W+1)'(1);
		at_end = cnt >= {1'b0, fl};
		place_bad = ({2'b0, cfg.origin_x} + 12'(SPRITE_WIDTH) > {1'b0, cfg.surface_width}) ||
			({2'b0, cfg.origin_y} + 12'(SPRITE_HEIGHT) > {1'b0, cfg.surface_height});
		run_len = {1'b0, data_byte[6:0]} + RUN_W'(1);
		need = data_byte[7] ? 9'd2 : {run_len, 1'b0};
		// bytes left after this one fall short of what the run needs
		trunc = {2'b0, fl} < ({1'b0, cnt} + {11'b0, need});

		err_n = err_q;
		phase_n = phase_q;
		pix_n = pix_q;
		fill_n = fill_q;
		rem_n = rem_q;
		hi_n = hi_q;
		span = 1'b0;
		span_len = '0;

		if (byte_idx_q == '0 && err_q == ST_OK && place_bad)
			err_n = ST_PLACE;

		if (err_n == ST_OK) begin
			case (phase_q)
				PH_CTRL: begin
					if ({1'b0, pix_q} >= TOTAL)
						err_n = ST_MISMATCH;
					else if ({1'b0, pix_q} + (PIX_W+1)'(run_len) > TOTAL)
						err_n = ST_OVERFLOW;
					else if (trunc)
						err_n = ST_TRUNC;
					else begin
						fill_n = data_byte[7];
						rem_n = data_byte[6:0];
						phase_n = PH_HI;
					end
				end
				PH_HI: begin
					hi_n = data_byte;
					phase_n = PH_LO;
				end
				PH_LO: begin
					span = 1'b1;
					span_len = fill_q ? ({1'b0, rem_q} + RUN_W'(1)) : RUN_W'(1);
					pix_n = pix_q + PIX_W'(span_len);
					if (fill_q || rem_q == '0) begin
						rem_n = '0;
						phase_n = PH_CTRL;
					end else begin
						rem_n = rem_q - 7'd1;
						phase_n = PH_HI;
					end
				end
				default: begin
					phase_n = PH_CTRL;
				end
			endcase
		end

		// frame end: report first error, else an unfinished run or pixel shortfall
		st = err_n;
		if (err_n == ST_OK) begin
			if (phase_n != PH_CTRL)
				st = ST_TRUNC;
			else if ({1'b0, pix_n} != TOTAL)
				st = ST_MISMATCH;
		end

		q_entry.has_span = span;
		q_entry.span_len = span_len;
		q_entry.color = {hi_q, data_byte};
		q_entry.has_status = at_end;
		q_entry.status = at_end ? st : ST_OK;
	end

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign q_push = accept && (span || at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			byte_idx_q <= '0;
			pix_q <= '0;
			fill_q <= 1'b0;
			rem_q <= '0;
			hi_q <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (at_end) begin
				phase_q <= PH_CTRL;
				byte_idx_q <= '0;
				pix_q <= '0;
				fill_q <= 1'b0;
				rem_q <= '0;
				hi_q <= '0;
				err_q <= ST_OK;
			end else begin
				phase_q <= phase_n;
				byte_idx_q <= cnt[BIDX_W-1:0];
				pix_q <= pix_n;
				fill_q <= fill_n;
				rem_q <= rem_n;
				hi_q <= hi_n;
				err_q <= err_n;
			end
		end
	end

endmodule

/* src/rsd_fifo.sv */
// Short work queue between front and back of the RLE sprite decoder.
// Uses rsd_pkg (entry_t, Q_DEPTH) and assert_macros.svh.
`include "assert_macros.svh"
module rsd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rsd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output rsd_pkg::entry_t head,
	output logic            empty
);
	import rsd_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);

	entry_t           mem [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full = count_q == (PTR_W+1)'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop && !empty)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`RSD_NEVER(a_push_when_full, clk, arst_n, push && full)
	`RSD_NEVER(a_pop_when_empty, clk, arst_n, pop && empty)
	`RSD_ASSERT(a_empty_ptrs_equal, clk, arst_n, empty |-> wr_ptr_q == rd_ptr_q)

endmodule

/* src/rsd_back.sv */
// Back end of the RLE sprite decoder: splits queued runs at sprite row ends,
// forms surface addresses and drives the result register.
// Uses rsd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rsd_back #(
	parameter int SPRITE_WIDTH  = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsd_pkg::cfg_t               cfg,
	input  rsd_pkg::entry_t             q_head,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [rsd_pkg::ADDR_W-1:0]  write_address,
	output logic [rsd_pkg::SPAN_W-1:0]  span_length,
	output logic [rsd_pkg::COLOR_W-1:0] pixel_color,
	output logic [2:0]                  status,
	output logic                        last
);
	import rsd_pkg::*;

	localparam int COL_W = $clog2(SPRITE_WIDTH);
	localparam int PROD_W = 22;

	entry_t             cur_q;
	logic               cur_valid_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	logic               out_valid_q, out_last_q;
	kind_t              out_kind_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [SPAN_W-1:0]  out_len_q;
	logic [COLOR_W-1:0] out_color_q;
	status_t            out_status_q;

	logic               adv, seg_done;
	logic [SPAN_W-1:0]  room, seg, col_sum, len_ext;
	logic [10:0]        y_sum;
	logic [PROD_W-1:0]  addr;

	// result register frees up when empty or being taken
	assign adv = !out_valid_q || out_ready;
	assign q_pop = !cur_valid_q && !q_empty;

	always_comb begin
		len_ext = {1'b0, cur_q.span_len};
		room = SPAN_W'(SPRITE_WIDTH) - SPAN_W'(col_q);
		seg = (len_ext < room) ? len_ext : room;
		seg_done = seg == len_ext;
		col_sum = SPAN_W'(col_q) + seg;
		y_sum = {1'b0, cfg.origin_y} + 11'(row_q);
		addr = PROD_W'(y_sum) * PROD_W'(cfg.surface_width) + PROD_W'(cfg.origin_x) +
			PROD_W'(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_kind_q <= KIND_SPAN;
			out_status_q <= ST_OK;
		end else begin
			if (q_pop)
				cur_valid_q <= 1'b1;
			if (adv) begin
				out_valid_q <= cur_valid_q;
				if (cur_valid_q) begin
					if (cur_q.has_span) begin
						out_kind_q <= KIND_SPAN;
						out_status_q <= ST_OK;
						out_last_q <= seg_done && !cur_q.has_status;
						if (col_sum >= SPAN_W'(SPRITE_WIDTH)) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_sum[COL_W-1:0];
						end
						if (seg_done && !cur_q.has_status)
							cur_valid_q <= 1'b0;
					end else begin
						// status closes the frame: rewind to the sprite origin
						out_kind_q <= KIND_STATUS;
						out_status_q <= cur_q.status;
						out_last_q <= 1'b1;
						col_q <= '0;
						row_q <= '0;
						cur_valid_q <= 1'b0;
					end
				end
			end
		end
	end

	// payload side of the current entry and of the result register
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		else if (adv && cur_valid_q && cur_q.has_span) begin
			cur_q.span_len <= RUN_W'(len_ext - seg);
			if (seg_done)
				cur_q.has_span <= 1'b0;
		end
		if (adv && cur_valid_q) begin
			if (cur_q.has_span) begin
				out_addr_q <= addr[ADDR_W-1:0];
				out_len_q <= seg;
				out_color_q <= cur_q.color;
			end else begin
				out_addr_q <= '0;
				out_len_q <= '0;
				out_color_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = out_kind_q;
	assign write_address = out_addr_q;
	assign span_length = out_len_q;
	assign pixel_color = out_color_q;
	assign status = out_status_q;
	assign last = out_last_q;

	`RSD_ASSERT(a_status_is_last, clk, arst_n, out_valid_q && out_kind_q == KIND_STATUS |-> out_last_q)
	`RSD_ASSERT(a_span_nonempty, clk, arst_n, out_valid_q && out_kind_q == KIND_SPAN |-> out_len_q != '0 && out_status_q == ST_OK)
	`RSD_ASSERT(a_entry_has_work, clk, arst_n, cur_valid_q && !cur_q.has_span |-> cur_q.has_status)

endmodule

/* src/rle_sprite_decoder_unit.sv */
// Top level of the RLE sprite decoder: configuration registers, front end,
// work queue and back end. Uses rsd_pkg, rsd_front, rsd_fifo and rsd_back.
//
// The block reads a run-length coded 16-bit sprite one byte per input item and
// writes framebuffer spans. A control byte gives a run of (low 7 bits + 1)
// pixels; with bit 7 set one color (high byte first) fills the run, otherwise
// that many literal colors follow. Fill runs are cut at sprite row ends; each
// literal pixel is a span of one. Address = (origin_y + row) * surface_width +
// origin_x + column, kept to 20 bits. The frame's last byte adds a status item
// (0 ok, 1 placement, 2 run overflow, 3 truncated, 4 count mismatch); after an
// error no spans are written. The front end takes one byte per cycle while the
// four-entry queue has room; the back end loads a queue entry only once it is
// through with the last one, then writes that entry's spans and any status one
// by one into the result register as the output takes them. A fill run across
// rows yields up to ceil(128 / SPRITE_WIDTH) + 1 spans. Program registers
// only while idle.
module rle_sprite_decoder_unit #(
	parameter int SPRITE_WIDTH  = 64,
	parameter int SPRITE_HEIGHT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rsd_pkg::DATA_W-1:0]     data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           kind,
	output logic [rsd_pkg::ADDR_W-1:0]     write_address,
	output logic [rsd_pkg::SPAN_W-1:0]     span_length,
	output logic [rsd_pkg::COLOR_W-1:0]    pixel_color,
	output logic [2:0]                     status,
	output logic                           last
);
	import rsd_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry, head_entry;
	logic   q_push, q_pop, q_full, q_empty;

	// register writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.surface_width <= 11'd1;
			cfg_q.surface_height <= 11'd1;
			cfg_q.frame_length <= BIDX_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X:       cfg_q.origin_x <= cfg_data[9:0];
				REG_ORIGIN_Y:       cfg_q.origin_y <= cfg_data[9:0];
				REG_SURFACE_WIDTH:  cfg_q.surface_width <= cfg_data[10:0];
				REG_SURFACE_HEIGHT: cfg_q.surface_height <= cfg_data[10:0];
				REG_FRAME_LENGTH:   cfg_q.frame_length <= cfg_data[BIDX_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// decode bytes and classify them into span and status work
	rsd_front #(
		.SPRITE_WIDTH  (SPRITE_WIDTH),
		.SPRITE_HEIGHT (SPRITE_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	// hold work so front and back stall independently
	rsd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head_entry),
		.empty      (q_empty)
	);

	// split runs into spans and drive the result register
	rsd_back #(
		.SPRITE_WIDTH  (SPRITE_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_head        (head_entry),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.write_address (write_address),
		.span_length   (span_length),
		.pixel_color   (pixel_color),
		.status        (status),
		.last          (last)
	);

endmodule
